// ===== sv/sil_pkg.sv =====
// ----------------------------------------------------------------------------
// sil_pkg: shared types and codes for the sorted insertion list
// Request and result structs, entry layout, request and status codes.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int KEY_W   = 32;
  localparam int TAG_W   = 16;
  localparam int IDX_W   = 6;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [KEY_W-1:0]   start_time;
    logic [TAG_W-1:0]   entry_tag;
    logic [IDX_W-1:0]   remove_index;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Broadcast from the control to every cell
  typedef struct packed {
    logic               ins_en;
    logic               rem_en;
    entry_t             fresh;
    logic [IDX_W-1:0]   remove_index;
  } cell_cmd_t;

endpackage

// ===== sv/sil_cell.sv =====
// ----------------------------------------------------------------------------
// sil_cell: one slot of the sorted insertion list
// Holds one entry, compares it with the incoming key and shifts up or down.
// ----------------------------------------------------------------------------
module sil_cell #(
  parameter int SLOT  = 0,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  sil_pkg::cell_cmd_t cmd,
  input  logic [CNT_W-1:0]   count,
  input  sil_pkg::entry_t    left_entry,
  input  logic               left_ge,
  input  sil_pkg::entry_t    right_entry,
  output sil_pkg::entry_t    entry,
  output logic               ge
);

  logic occupied;

  // Slot holds a live entry when it lies below the fill count
  assign occupied = SLOT < int'(count);

  // Slot lies at or after the insertion point: empty, or strictly later key
  assign ge = !occupied || (cmd.fresh.key < entry.key);

  // Shift on insert or remove, otherwise hold
  always_ff @(posedge clk) begin
    if (cmd.ins_en && ge) begin
      if (left_ge) begin
        entry <= left_entry;
      end else begin
        entry <= cmd.fresh;
      end
    end else if (cmd.rem_en && (SLOT >= int'(cmd.remove_index))) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== sv/sil_pos_enc.sv =====
// ----------------------------------------------------------------------------
// sil_pos_enc: thermometer to binary encoder
// Counts the leading run of ones by a binary search over the code.
// ----------------------------------------------------------------------------
module sil_pos_enc #(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7
) (
  input  logic [DEPTH-1:0] thermo,
  output logic [CNT_W-1:0] count
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] cand;
  logic [CNT_W-1:0] cand_m1;

  // Settle one result bit per step, most significant first
  always_comb begin
    pos     = '0;
    cand    = '0;
    cand_m1 = '0;
    for (int b = CNT_W - 1; b >= 0; b--) begin
      cand    = pos | (CNT_W'(1) << b);
      cand_m1 = cand - CNT_W'(1);
      if ((int'(cand) <= DEPTH) && thermo[cand_m1[IdxW-1:0]]) begin
        pos = cand;
      end
    end
    count = pos;
  end

endmodule

// ===== sv/sorted_insert_list_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_list_unit: table of entries kept in order of start time
// Insert places an entry after all stored entries with an equal or earlier
// start; remove deletes the entry at an index and closes the gap.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy
//   stays low: every slot compares and shifts in the cycle of the request,
//   so a new request may follow in every cycle.
//   The result appears on result after the stage one and result registers,
//   marked by a one-cycle done strobe. The slot row's compare bits are
//   registered in stage one, and the insert position is encoded from them.
//   result.position is the slot the entry went to (zero on remove and on a
//   refused request), result.status reports ok, table full or index out of
//   range, result.entry_count is the fill after the request.
//   Throughput is one request per cycle.
//   Reset empties the table and drops requests in flight; no sweep follows.
//   The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_insert_list_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sil_pkg::req_t  request,
  output logic           busy,
  output logic           done,
  output sil_pkg::rsp_t  result
);

  localparam int CntW   = $clog2(TABLE_DEPTH + 1);
  localparam int PosW   = sil_pkg::POS_W;
  localparam int CountW = sil_pkg::COUNT_W;

  logic                accept;
  logic                full;
  logic                rem_ok;
  logic [CntW-1:0]     count;
  logic [CntW-1:0]     count_next;
  sil_pkg::cell_cmd_t  cmd;

  sil_pkg::entry_t     entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ge;
  logic [TABLE_DEPTH-1:0] thermo;

  // Stage one registers
  logic                s1_valid;
  logic [1:0]          s1_status;
  logic [TABLE_DEPTH-1:0] s1_thermo;
  logic [CntW-1:0]     s1_count;
  logic [CntW-1:0]     s1_pos;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the request against the current fill
  assign full   = count == CntW'(TABLE_DEPTH);
  assign rem_ok = int'(request.remove_index) < int'(count);

  always_comb begin
    cmd              = '0;
    cmd.fresh.key    = request.start_time;
    cmd.fresh.tag    = request.entry_tag;
    cmd.remove_index = request.remove_index;
    cmd.ins_en       = accept && (request.req_type == sil_pkg::REQ_INSERT) && !full;
    cmd.rem_en       = accept && (request.req_type == sil_pkg::REQ_REMOVE) && rem_ok;
  end

  always_comb begin
    count_next = count;
    if (cmd.ins_en) begin
      count_next = count + CntW'(1);
    end else if (cmd.rem_en) begin
      count_next = count - CntW'(1);
    end
  end

  // Build the row of slots
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
    sil_pkg::entry_t left_entry;
    sil_pkg::entry_t right_entry;
    logic            left_ge;

    if (i == 0) begin : g_first
      assign left_entry = entries[i];
      assign left_ge    = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sil_cell #(
      .SLOT  (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .ge          (ge[i])
    );

    // Slots before the insertion point form the leading run of ones
    assign thermo[i] = !ge[i];
  end

  // Hold fill count and stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
    end else begin
      count    <= count_next;
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_count  <= count_next;
    s1_thermo <= cmd.ins_en ? thermo : '0;
    if (cmd.ins_en || cmd.rem_en) begin
      s1_status <= sil_pkg::ST_OK;
    end else if (request.req_type == sil_pkg::REQ_INSERT) begin
      s1_status <= sil_pkg::ST_FULL;
    end else begin
      s1_status <= sil_pkg::ST_RANGE;
    end
  end

  sil_pos_enc #(
    .DEPTH (TABLE_DEPTH),
    .CNT_W (CntW)
  ) u_pos_enc (
    .thermo (s1_thermo),
    .count  (s1_pos)
  );

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.position    <= PosW'(s1_pos);
    result.status      <= s1_status;
    result.entry_count <= CountW'(s1_count);
  end

endmodule

// ===== sv/sil_checker.sv =====
// ----------------------------------------------------------------------------
// sil_checker: port-level checks for the sorted insertion list
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module sil_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input sil_pkg::rsp_t result
);

  localparam int CountW = sil_pkg::COUNT_W;

  // Every request gives its result, marked by done
  a_req_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("request without result");

  // No result without an earlier request
  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without request");

  // A refused request reports position zero
  a_refused_pos: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != sil_pkg::ST_OK)) |-> (result.position == '0))
    else $error("refused request with nonzero position");

  // A full refusal reports the table at its depth
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == sil_pkg::ST_FULL)) |->
      (result.entry_count == CountW'(TABLE_DEPTH)))
    else $error("table full reported below depth");

endmodule

bind sorted_insert_list_unit sil_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_sil_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
